### rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// shared types and constants of the sobel gradient magnitude core
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int MAG_W      = 11;
  localparam int PIX_IN_W   = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int RC_W       = FH_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0]  FW_RESET = 11'd640;
  localparam logic [FH_W-1:0]  FH_RESET = 16'd480;
  localparam logic [FH_W-1:0]  FH_MIN   = 16'd3;
  localparam logic [MAG_W-1:0] MAG_MAX  = {MAG_W{1'b1}};

  typedef struct packed {
    logic vld;
    logic last;
  } sgm_tag_t;

endpackage

### rtl/sgm_linebuf.sv
// ----------------------------------------------------------------------------
// sgm_linebuf
// line buffer memory, one entry per column holding the two older rows,
// registered read with write-to-read forwarding on the same entry
// ----------------------------------------------------------------------------
module sgm_linebuf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] q_r;
  logic [DW-1:0] fwd_data_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // read and write of one entry in the same cycle: take the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

### rtl/sgm_sqrt.sv
// ----------------------------------------------------------------------------
// sgm_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module sgm_sqrt import sgm_pkg::*; #(
  parameter int RB = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sgm_tag_t          in_tag,
  input  logic [2*RB-1:0]   in_rad,
  output sgm_tag_t          out_tag,
  output logic [RB-1:0]     out_root
);

  sgm_tag_t          tag_r   [RB];
  logic [2*RB-1:0]   rad_r   [RB];
  logic [RB+1:0]     rem_r   [RB];
  logic [RB-1:0]     root_r  [RB];

  sgm_tag_t          tag_in  [RB];
  logic [2*RB-1:0]   rad_in  [RB];
  logic [RB+1:0]     rem_in  [RB];
  logic [RB-1:0]     root_in [RB];
  logic [RB+1:0]     rem_sh  [RB];
  logic [RB+1:0]     trial   [RB];
  logic [RB+1:0]     rem_nx  [RB];
  logic [RB-1:0]     root_nx [RB];
  logic [2*RB-1:0]   rad_nx  [RB];
  logic              ge      [RB];

  always_comb begin
    for (int k = 0; k < RB; k++) begin
      if (k == 0) begin
        tag_in[k]  = in_tag;
        rad_in[k]  = in_rad;
        rem_in[k]  = '0;
        root_in[k] = '0;
      end else begin
        tag_in[k]  = tag_r[k-1];
        rad_in[k]  = rad_r[k-1];
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
      end
      rem_sh[k]  = {rem_in[k][RB-1:0], rad_in[k][2*RB-1 -: 2]};
      trial[k]   = {root_in[k], 2'b01};
      ge[k]      = rem_sh[k] >= trial[k];
      rem_nx[k]  = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      root_nx[k] = {root_in[k][RB-2:0], ge[k]};
      rad_nx[k]  = {rad_in[k][2*RB-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RB; k++) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else begin
        tag_r[k] <= tag_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RB; k++) begin
      rad_r[k]  <= rad_nx[k];
      rem_r[k]  <= rem_nx[k];
      root_r[k] <= root_nx[k];
    end
  end

  assign out_tag  = tag_r[RB-1];
  assign out_root = root_r[RB-1];

endmodule

### rtl/sgm_out_fifo.sv
// ----------------------------------------------------------------------------
// sgm_out_fifo
// result queue in front of the output channel, power-of-two depth
// ----------------------------------------------------------------------------
module sgm_out_fifo #(
  parameter int DEPTH  = 32,
  parameter int DW     = 12,
  localparam int AW    = $clog2(DEPTH),
  localparam int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  output logic          rd_valid,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + CNTW'(wr_en) - CNTW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rd_ptr_r];

endmodule

### rtl/sobel_gradient_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_core
// streaming 3x3 sobel gradient magnitude over a raster pixel stream
// ----------------------------------------------------------------------------
// usage
//   input words carry in_mode and in_pixel in raster order: frame_width *
//   frame_height pixel words, then frame_width + 1 flush words. every word
//   from position frame_width + 1 on gives one output word (out_magnitude,
//   out_last_of_frame), in raster order, one row plus one pixel behind.
//   border positions give zero; the final word of a frame is flagged and
//   the block starts the next frame on its own.
//   a word is taken at a clock edge with valid high and stall low.
//   throughput is one word per cycle while in_stall stays low. on its way
//   to an output word an input word passes through the line buffer
//   read at the accept edge, then gradient, squares, sum, one
//   square-root bit per stage and the result queue write.
//   a result queue at least as deep as the pipeline absorbs output stalls; in_stall
//   rises only when every queue slot is spoken for.
//   cfg writes (only while idle) restart the frame; the line buffers keep
//   their contents. after reset: width 640, height 480, no words pending.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_core import sgm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [PIX_IN_W-1:0]   in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MAG_W-1:0]      out_magnitude,
  output logic                  out_last_of_frame
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int GW         = PIXEL_BITS + 2;
  localparam int SQW        = 2 * GW;
  localparam int RB         = PIXEL_BITS + 3;
  localparam int RW         = 2 * RB;
  localparam int XW         = RB + MAG_W;
  localparam int FIFO_DEPTH = 1 << $clog2(RB + 6);
  localparam int OW         = $clog2(FIFO_DEPTH + 1);
  localparam logic [WW-1:0] MAX_W_V = WW'(MAX_WIDTH);

  function automatic logic [CW-1:0] width_last(input logic [FW_W-1:0] v);
    logic [WW-1:0] ve;
    logic [WW-1:0] t;
    ve = WW'(v);
    if (ve < WW'(3)) begin
      t = WW'(2);
    end else if (ve > MAX_W_V) begin
      t = MAX_W_V - WW'(1);
    end else begin
      t = ve - WW'(1);
    end
    return t[CW-1:0];
  endfunction

  // configuration and frame position
  logic [CW-1:0]         col_last_r;
  logic [FH_W-1:0]       hgt_r;
  logic [CW-1:0]         col_r;
  logic [RC_W-1:0]       row_r;
  logic [FH_W-1:0]       hgt_wr;
  logic [OW-1:0]         occ_r;
  logic [OW-1:0]         occ_nxt;

  // accept stage
  logic                  accept;
  logic [PIXEL_BITS+PIX_IN_W-1:0] pix_ext;
  logic [PIXEL_BITS-1:0] pix0;
  logic                  col_zero;
  logic                  row_ge2;
  logic                  prod0;
  logic                  int0;
  logic                  last0;
  logic [RC_W-1:0]       last_row;

  // line buffer stage
  logic                  s1_vld_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [CW-1:0]         s1_col_r;
  logic                  s1_prod_r;
  logic                  s1_int_r;
  logic                  s1_last_r;
  logic [2*PIXEL_BITS-1:0] lb_q;
  logic [PIXEL_BITS-1:0] n0;
  logic [PIXEL_BITS-1:0] n1;
  logic [PIXEL_BITS-1:0] n2;
  logic [PIXEL_BITS-1:0] win_r [6];
  logic [GW-1:0]         px_p;
  logic [GW-1:0]         px_m;
  logic [GW-1:0]         py_p;
  logic [GW-1:0]         py_m;
  logic [GW-1:0]         gx_abs;
  logic [GW-1:0]         gy_abs;
  logic                  drop;

  // arithmetic stages
  sgm_tag_t              s2_tag_r;
  logic [GW-1:0]         s2_gx_r;
  logic [GW-1:0]         s2_gy_r;
  sgm_tag_t              s3_tag_r;
  logic [SQW-1:0]        s3_sqx_r;
  logic [SQW-1:0]        s3_sqy_r;
  sgm_tag_t              s4_tag_r;
  logic [RW-1:0]         s4_rad_r;
  sgm_tag_t              sq_tag;
  logic [RB-1:0]         sq_root;
  logic [XW-1:0]         root_ext;
  logic [MAG_W-1:0]      mag_sat;
  logic                  pop;
  logic [MAG_W:0]        fifo_q;

  assign in_stall = occ_r == OW'(FIFO_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign drop     = s1_vld_r && !s1_prod_r;

  always_comb begin
    pix_ext  = {{PIXEL_BITS{1'b0}}, in_pixel};
    pix0     = in_mode ? '0 : pix_ext[PIXEL_BITS-1:0];
    col_zero = col_r == '0;
    row_ge2  = row_r >= RC_W'(2);
    last_row = {1'b0, hgt_r} + RC_W'(1);
    prod0    = row_ge2 || ((row_r == RC_W'(1)) && !col_zero);
    int0     = (col_r >= CW'(2)) && row_ge2 && (row_r < {1'b0, hgt_r});
    last0    = col_zero && (row_r == last_row);
    hgt_wr   = (cfg_data[FH_W-1:0] < FH_MIN) ? FH_MIN : cfg_data[FH_W-1:0];
    occ_nxt  = occ_r + OW'(accept) - OW'(pop) - OW'(drop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= width_last(FW_RESET);
      hgt_r      <= FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  col_last_r <= width_last(cfg_data[FW_W-1:0]);
        REG_FRAME_HEIGHT: hgt_r      <= hgt_wr;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_we) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (last0) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_r == col_last_r) begin
          col_r <= '0;
          row_r <= row_r + RC_W'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix0;
      s1_col_r  <= col_r;
      s1_prod_r <= prod0;
      s1_int_r  <= int0;
      s1_last_r <= last0;
    end
  end

  sgm_linebuf #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIXEL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (lb_q),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_col_r),
    .wr_data ({n1, n2})
  );

  // entry holds older row above previous row
  assign n0 = lb_q[2*PIXEL_BITS-1:PIXEL_BITS];
  assign n1 = lb_q[PIXEL_BITS-1:0];
  assign n2 = s1_pix_r;

  always_comb begin
    px_p   = GW'(n0) + (GW'(n1) << 1) + GW'(n2);
    px_m   = GW'(win_r[0]) + (GW'(win_r[1]) << 1) + GW'(win_r[2]);
    py_p   = GW'(win_r[2]) + (GW'(win_r[5]) << 1) + GW'(n2);
    py_m   = GW'(win_r[0]) + (GW'(win_r[3]) << 1) + GW'(n0);
    gx_abs = (px_p >= px_m) ? (px_p - px_m) : (px_m - px_p);
    gy_abs = (py_p >= py_m) ? (py_p - py_m) : (py_m - py_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_vld_r) begin
      if (s1_last_r) begin
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= n0;
        win_r[4] <= n1;
        win_r[5] <= n2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
    end else begin
      s2_tag_r <= '{vld: s1_vld_r && s1_prod_r, last: s1_last_r};
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_gx_r  <= s1_int_r ? gx_abs : '0;
    s2_gy_r  <= s1_int_r ? gy_abs : '0;
    s3_sqx_r <= s2_gx_r * s2_gx_r;
    s3_sqy_r <= s2_gy_r * s2_gy_r;
    s4_rad_r <= RW'(s3_sqx_r) + RW'(s3_sqy_r);
  end

  sgm_sqrt #(
    .RB (RB)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s4_tag_r),
    .in_rad   (s4_rad_r),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  always_comb begin
    root_ext = XW'(sq_root);
    mag_sat  = (root_ext > XW'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
  end

  sgm_out_fifo #(
    .DEPTH (FIFO_DEPTH),
    .DW    (MAG_W + 1)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (sq_tag.vld),
    .wr_data  ({mag_sat, sq_tag.last}),
    .rd_en    (pop),
    .rd_valid (out_valid),
    .rd_data  (fifo_q)
  );

  assign out_magnitude     = fifo_q[MAG_W:1];
  assign out_last_of_frame = fifo_q[0];

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(FIFO_DEPTH))
    else $error("queue slots overcommitted");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last_r)
    else $error("column past row end");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= last_row)
    else $error("row past flush row");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last0 && !cfg_we |=> (col_r == '0) && (row_r == '0))
    else $error("frame did not restart after last word");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_int_r |=> (s2_gx_r == '0) && (s2_gy_r == '0))
    else $error("border gradient not zero");
`endif

endmodule
